// File: hdl/h263qd_pkg.sv
// ----------------------------------------------------------------------------
// h263qd_pkg
// Shared types and constants of the H.263 block quantizer / dequantizer.
// ----------------------------------------------------------------------------
package h263qd_pkg;

  typedef enum logic [1:0] {
    MODE_INTRA_Q  = 2'd0,
    MODE_INTER_Q  = 2'd1,
    MODE_INTRA_DQ = 2'd2,
    MODE_INTER_DQ = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_QUANT = 2'd1,
    REG_DCS   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_mode;
  } stat_t;

  localparam int DIV_STEPS = 17;
  localparam int DIV_CW    = 5;

  localparam logic signed [15:0] CLAMP_HI = 16'sd2047;
  localparam logic signed [15:0] CLAMP_LO = -16'sd2048;

  // 65536 / (2q) + 1, indexed by q; entry 0 is never used
  localparam logic [15:0] RECIP_TBL [32] = '{
    16'd32769, 16'd32769, 16'd16385, 16'd10923, 16'd8193, 16'd6554, 16'd5462, 16'd4682,
    16'd4097,  16'd3641,  16'd3277,  16'd2979,  16'd2731, 16'd2521, 16'd2341, 16'd2185,
    16'd2049,  16'd1928,  16'd1821,  16'd1725,  16'd1639, 16'd1561, 16'd1490, 16'd1425,
    16'd1366,  16'd1311,  16'd1261,  16'd1214,  16'd1171, 16'd1130, 16'd1093, 16'd1058
  };

endpackage

// File: hdl/h263qd_ctrl.sv
// ----------------------------------------------------------------------------
// h263qd_ctrl
// Sequencer: accept, multiply or iterative DC divide, then load output register.
// ----------------------------------------------------------------------------
module h263qd_ctrl
  import h263qd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t            state_r, state_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = stat.div_mode ? ST_DIV : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while full");

  a_accept_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_MUL || state_r == ST_DIV))
    else $error("accepted transaction not processed");

  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("output valid raised outside finish");
`endif

endmodule

// File: hdl/h263qd_dpath.sv
// ----------------------------------------------------------------------------
// h263qd_dpath
// Configuration registers, block position, level sum, multiplier, DC divider.
// ----------------------------------------------------------------------------
module h263qd_dpath
  import h263qd_pkg::*;
#(
  parameter int BLOCK_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  input  logic signed [15:0] in_value_in,
  input  logic               in_last_in,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic signed [15:0] out_value_out,
  output logic               out_last_out,
  output logic [16:0]        out_level_sum
);

  localparam int PW = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;

  logic [1:0]         mode_r;
  logic [4:0]         quant_r;
  logic [5:0]         dcs_r;
  logic [PW-1:0]      pos_r;
  logic [16:0]        sum_r;
  logic signed [15:0] c_r;
  logic               last_r;
  logic [16:0]        dq_r;
  logic [5:0]         rem_r;
  logic               dneg_r;
  logic signed [35:0] prod_r;
  logic signed [15:0] value_r;
  logic               olast_r;
  logic [16:0]        osum_r;

  logic [4:0]         q_eff;
  logic [5:0]         s_eff;
  logic [4:0]         k_val;
  logic [15:0]        recip;
  logic               is_dc;
  logic               div_mode;
  logic signed [16:0] v_ext, d_pos, d_neg, d_sel;
  logic [16:0]        d_mag, c_abs, a_sub;
  logic [3:0]         q_half;
  logic [7:0]         trial;
  logic signed [17:0] op_a, op_b;
  logic               neg;
  logic signed [16:0] cr_ext;
  logic [16:0]        cr_abs;
  logic [15:0]        half;
  logic [16:0]        lv;
  logic [15:0]        t_raw, t_adj;
  logic [15:0]        dq_term;
  logic [15:0]        res;
  logic [16:0]        sum_new;
  logic               block_end;

  function automatic logic [15:0] clamp12(input logic signed [35:0] v);
    logic [15:0] r;
    if (v > 36'(CLAMP_HI)) begin
      r = CLAMP_HI;
    end else if (v < 36'(CLAMP_LO)) begin
      r = CLAMP_LO;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign q_eff    = (quant_r == 5'd0) ? 5'd1 : quant_r;
  assign s_eff    = (dcs_r == 6'd0) ? 6'd1 : dcs_r;
  assign k_val    = q_eff[0] ? q_eff : q_eff - 5'd1;
  assign recip    = RECIP_TBL[q_eff];
  assign is_dc    = (pos_r == '0);
  assign div_mode = (mode_r == MODE_INTRA_Q) && is_dc;
  assign stat.div_mode = div_mode;

  always_comb begin
    v_ext  = {in_value_in[15], in_value_in};
    d_pos  = v_ext + $signed({12'b0, s_eff[5:1]});
    d_neg  = v_ext - $signed({12'b0, s_eff[5:1]});
    d_sel  = d_pos[16] ? d_neg : d_pos;
    d_mag  = d_sel[16] ? 17'(-d_sel) : 17'(d_sel);
    c_abs  = in_value_in[15] ? 17'(-v_ext) : 17'(v_ext);
    q_half = q_eff[4:1];
    a_sub  = (c_abs > {13'b0, q_half}) ? c_abs - {13'b0, q_half} : 17'd0;
    trial  = {1'b0, rem_r, dq_r[16]} - {2'b0, s_eff};
  end

  always_comb begin
    op_a = (mode_r == MODE_INTER_Q) ? $signed({1'b0, dq_r}) : 18'(c_r);
    if (mode_r == MODE_INTRA_Q || mode_r == MODE_INTER_Q) begin
      op_b = $signed({2'b0, recip});
    end else if (mode_r == MODE_INTRA_DQ && is_dc) begin
      op_b = $signed({12'b0, s_eff});
    end else begin
      op_b = $signed({12'b0, q_eff, 1'b0});
    end
  end

  always_comb begin
    neg     = c_r[15];
    cr_ext  = {c_r[15], c_r};
    cr_abs  = neg ? 17'(-cr_ext) : 17'(cr_ext);
    half    = cr_abs[16:1];
    lv      = (q_eff == 5'd1) ? {1'b0, dq_r[16:1]} : prod_r[32:16];
    t_raw   = prod_r[15:0];
    t_adj   = neg ? t_raw - {11'b0, k_val} : t_raw + {11'b0, k_val};
    dq_term = (c_r == 16'sd0) ? 16'd0 : clamp12(36'($signed(t_adj)));
    unique case (mode_r)
      MODE_INTRA_Q: begin
        if (is_dc) begin
          res = dneg_r ? 16'(-dq_r[15:0]) : dq_r[15:0];
        end else if (q_eff == 5'd1) begin
          res = neg ? 16'(-half) : half;
        end else begin
          res = prod_r[31:16] + {15'b0, neg};
        end
      end
      MODE_INTER_Q:  res = neg ? 16'(-lv[15:0]) : lv[15:0];
      MODE_INTRA_DQ: res = is_dc ? clamp12(prod_r) : dq_term;
      MODE_INTER_DQ: res = dq_term;
      default:       res = dq_term;
    endcase
    sum_new   = sum_r + lv;
    block_end = last_r || (pos_r == PW'(BLOCK_SIZE - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_INTRA_Q;
      quant_r <= 5'd1;
      dcs_r   <= 6'd8;
      pos_r   <= '0;
      sum_r   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:  mode_r  <= cfg_data[1:0];
          REG_QUANT: quant_r <= cfg_data[4:0];
          REG_DCS:   dcs_r   <= cfg_data;
          default:   ;
        endcase
      end
      if (cmd.load_out) begin
        pos_r <= block_end ? '0 : pos_r + 1'b1;
        if (block_end) begin
          sum_r <= '0;
        end else if (mode_r == MODE_INTER_Q) begin
          sum_r <= sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_r    <= in_value_in;
      last_r <= in_last_in;
      dq_r   <= div_mode ? d_mag : a_sub;
      dneg_r <= d_sel[16];
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= trial[7] ? {rem_r[4:0], dq_r[16]} : trial[5:0];
      dq_r  <= {dq_r[15:0], ~trial[7]};
    end
    if (cmd.mul) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.load_out) begin
      value_r <= res;
      olast_r <= last_r;
      osum_r  <= (mode_r == MODE_INTER_Q && last_r) ? sum_new : 17'd0;
    end
  end

  assign out_value_out = value_r;
  assign out_last_out  = olast_r;
  assign out_level_sum = osum_r;

endmodule

// File: hdl/h263_block_quant_dequant.sv
// ----------------------------------------------------------------------------
// h263_block_quant_dequant
// H.263 quantizer / dequantizer for a stream of 8x8 block coefficients.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one coefficient per transaction
//   in raster order, in_last_in marking the final coefficient of a block; a
//   block also ends after BLOCK_SIZE coefficients. The first coefficient of a
//   block is the DC term.
//   Output channel (out_valid/out_ready) returns one result per coefficient;
//   out_level_sum carries the inter level sum on a result marked by in_last_in;
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes mode,
//   quant_step and dc_scaler by index; write only while the block is idle.
// Timing:
//   One coefficient at a time. Most coefficients pass through accept, one
//   registered multiply and output load. The intra quantize DC term instead
//   passes through the 17-step restoring divider by dc_scaler.
//   The result enters the output register once that register is free. A
//   stalled receiver holds the result there; the next coefficient is still
//   accepted and processed up to its output load.
// Reset:
//   Synchronous, active low. Registers return to mode 0, quant_step 1,
//   dc_scaler 8; the next coefficient is a DC term and the level sum is zero.
// ----------------------------------------------------------------------------
module h263_block_quant_dequant
  import h263qd_pkg::*;
#(
  parameter int BLOCK_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_value_in,
  input  logic               in_last_in,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_value_out,
  output logic               out_last_out,
  output logic [16:0]        out_level_sum
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  h263qd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  h263qd_dpath #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_value_in   (in_value_in),
    .in_last_in    (in_last_in),
    .cmd           (cmd),
    .stat          (stat),
    .out_value_out (out_value_out),
    .out_last_out  (out_last_out),
    .out_level_sum (out_level_sum)
  );

endmodule
